FILE: rtl/cet_pkg.sv
// Shared types and constants for the cubic ease-in-out tween unit.
// No dependencies.
package cet_pkg;

  // Ratio and ease fraction precision (unsigned Q0.16 / Q1.16).
  localparam int unsigned FracBits  = 16;
  // Multiplier digit size and the digit shift register length.
  localparam int unsigned DigitBits = 4;
  localparam int unsigned MulBBits  = 20;
  // Digits per multiply: 16-bit operand, then the 17-bit ease fraction.
  localparam logic [3:0]  CubeDigits  = 4'd4;
  localparam logic [3:0]  ScaleDigits = 4'd5;
  localparam logic [3:0]  DivSteps    = 4'd15;
  localparam logic [16:0] FracOne     = 17'h10000;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_RETARGET = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_SQR   = 6'b000100,
    ST_CUBE  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

FILE: rtl/cubic_ease_tween_scalar_unit.sv
// Cubic ease-in-out tween of one signed Q16.16 value, digit-serial datapath.
// Depends on cet_pkg.

// One item is taken at a time. A retarget, a tick while idle, and the tick that
// ends an animation go straight from the input transfer to the finish state. Any
// other tick runs the radix-2 ratio divider, the radix-16 square and cube, and
// the radix-16 scale by the ease fraction; the finish state then loads the
// output register once it is free. The output register holds a
// result until its transfer; the next input is taken once the previous result
// is in that register. current_value_o is the eased value after the item and
// done_res_o is set when no animation is running.
module cubic_ease_tween_scalar_unit #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic signed [VALUE_WIDTH-1:0] target_value_i,
  input  logic        [TICK_WIDTH-1:0]  duration_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] current_value_o,
  output logic                          done_res_o
);
  import cet_pkg::*;

  localparam int unsigned AW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int unsigned PW = AW + MulBBits;

  state_e state_q, state_d;

  logic signed [VALUE_WIDTH-1:0] start_q, start_d;
  logic signed [VALUE_WIDTH-1:0] end_q, end_d;
  logic signed [VALUE_WIDTH-1:0] cur_q, cur_d;
  logic [TICK_WIDTH-1:0]         len_q, len_d;
  logic [TICK_WIDTH-1:0]         pos_q, pos_d;

  logic [TICK_WIDTH:0]   rem_q, rem_d;
  logic [FracBits-1:0]   quo_q, quo_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  hi_q, hi_d;
  logic                  up_q, up_d;
  logic [FracBits-1:0]   x_q, x_d;
  logic [AW-1:0]         mul_a_q, mul_a_d;
  logic [MulBBits-1:0]   mul_b_q, mul_b_d;
  logic [PW-1:0]         acc_q, acc_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic                          out_done_q, out_done_d;

  logic                   in_xfer;
  logic [TICK_WIDTH-1:0]  pos_inc;
  logic [TICK_WIDTH:0]    rem_dbl;
  logic                   quo_bit;
  logic [16:0]            x_wide;
  logic [DigitBits-1:0]   digit;
  logic [AW+3:0]          partial;
  logic [PW-1:0]          acc_sum;
  logic [15:0]            cube_hi;
  logic [16:0]            frac;
  logic                   up_now;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] step;
  logic                   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign pos_inc = pos_q + TICK_WIDTH'(1);

  // Restoring divide step: remainder stays below len, so the doubled value fits.
  assign rem_dbl = {rem_q[TICK_WIDTH-1:0], 1'b0};
  assign quo_bit = (rem_dbl >= {1'b0, len_q});

  // Digit-serial multiply, most significant digit first.
  assign digit   = mul_b_q[MulBBits-1 -: DigitBits];
  assign partial = {{DigitBits{1'b0}}, mul_a_q} * {{AW{1'b0}}, digit};
  assign acc_sum = {acc_q[PW-DigitBits-1:0], {DigitBits{1'b0}}}
                   + {{(PW-AW-DigitBits){1'b0}}, partial};

  // Mirrored operand reaches 0.5, whose cube term is 2^15.
  assign x_wide  = FracOne - {1'b0, quo_d};
  assign cube_hi = acc_sum[45:30];
  assign frac    = hi_q ? (FracOne - {1'b0, cube_hi}) : {1'b0, cube_hi};
  assign up_now  = (end_q >= start_q);
  assign mag     = up_now ? VALUE_WIDTH'(end_q - start_q) : VALUE_WIDTH'(start_q - end_q);
  assign step    = acc_sum[VALUE_WIDTH+FracBits-1:FracBits];

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    end_d       = end_q;
    cur_d       = cur_q;
    len_d       = len_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    hi_d        = hi_q;
    up_d        = up_q;
    x_d         = x_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_done_d  = out_done_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_FIN;
          if (operation_i == OP_RETARGET) begin
            // cur_q is the value shown after the last item, so no jump.
            start_d = cur_q;
            end_d   = target_value_i;
            len_d   = duration_ticks_i;
            pos_d   = '0;
            if (duration_ticks_i == '0) begin
              cur_d = target_value_i;
            end
          end else if (len_q != '0) begin
            if (pos_inc == len_q) begin
              len_d = '0;
              cur_d = end_q;
            end else begin
              pos_d   = pos_inc;
              rem_d   = {1'b0, pos_inc};
              quo_d   = '0;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        rem_d = quo_bit ? (rem_dbl - {1'b0, len_q}) : rem_dbl;
        quo_d = {quo_q[FracBits-2:0], quo_bit};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DivSteps) begin
          // Mirror the upper half so the cube always runs on a value <= 0.5.
          hi_d    = quo_d[FracBits-1];
          x_d     = quo_d[FracBits-1] ? x_wide[FracBits-1:0] : quo_d;
          mul_a_d = AW'(x_d);
          mul_b_d = {x_d, {DigitBits{1'b0}}};
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_SQR;
        end
      end

      ST_SQR: begin
        acc_d   = acc_sum;
        mul_b_d = mul_b_q << DigitBits;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == CubeDigits - 4'd1) begin
          mul_a_d = AW'(acc_sum[31:0]);
          mul_b_d = {x_q, {DigitBits{1'b0}}};
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_CUBE;
        end
      end

      ST_CUBE: begin
        acc_d   = acc_sum;
        mul_b_d = mul_b_q << DigitBits;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == CubeDigits - 4'd1) begin
          up_d    = up_now;
          mul_a_d = AW'(mag);
          mul_b_d = {3'b0, frac};
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_SCALE;
        end
      end

      ST_SCALE: begin
        acc_d   = acc_sum;
        mul_b_d = mul_b_q << DigitBits;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == ScaleDigits - 4'd1) begin
          // Step is truncated toward start.
          cur_d   = up_q ? (start_q + $signed(step)) : (start_q - $signed(step));
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = cur_q;
          out_done_d  = (len_q == '0);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      end_q       <= '0;
      cur_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      end_q       <= end_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    hi_q        <= hi_d;
    up_q        <= up_d;
    x_q         <= x_d;
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = out_value_q;
  assign done_res_o      = out_done_q;

`ifndef SYNTHESIS
  a_pos_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (pos_q < len_q))
    else $error("tick position reached the animation length while running");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("accepted item did not start processing");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && !out_valid_q) |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished result not loaded into the output register");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SQR) || (state_q == ST_CUBE)) |-> (cnt_q < CubeDigits))
    else $error("multiply digit counter overran");
`endif

endmodule
